/* rtl/core/lpfs_pkg.sv */
// ----------------------------------------------------------------------------
// lpfs_pkg - shared types and constants of the LED panel frame store
//
// Command codes, result kinds, the panel bit layout and the control bundle
// that drives the page serialiser.
// ----------------------------------------------------------------------------
package lpfs_pkg;

	// firmware command codes
	localparam logic [2:0] CmdWrite  = 3'd0;
	localparam logic [2:0] CmdRead   = 3'd1;
	localparam logic [2:0] CmdRotate = 3'd2;
	localparam logic [2:0] CmdClear  = 3'd3;
	localparam logic [2:0] CmdFlush  = 3'd4;

	// result kinds
	localparam logic KindPixel = 1'b0;
	localparam logic KindPanel = 1'b1;

	// panel layout: 8 rows of 10 bits per page, first bit of a row is the blink bit
	localparam int BitsPerRow   = 10;
	localparam int RowsPerPage  = 8;
	localparam int PageBits     = BitsPerRow * RowsPerPage;
	localparam int ColsPerPage  = 9;
	localparam int BytesPerPage = PageBits / 8;

	localparam logic [7:0] PixelSet = 8'hFF;

	// control bundle from the sequencer to the page serialiser
	typedef struct packed {
		logic       clr;    // zero the page vector
		logic       we;     // load one column into the page vector
		logic [3:0] idx;    // column within the page, 0..8
		logic       shift;  // drop the low byte
	} page_ctl_t;

endpackage

/* rtl/core/lpfs_ram.sv */
// ----------------------------------------------------------------------------
// lpfs_ram - generic single-write, single-read RAM
//
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lpfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 37
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/lpfs_addr_wrap.sv */
// ----------------------------------------------------------------------------
// lpfs_addr_wrap - logical to physical column address
//
// The store is rotated by moving a base offset, so every access adds the
// offset to the logical column and wraps once at the store depth.
// ----------------------------------------------------------------------------
module lpfs_addr_wrap #(
	parameter int DEPTH = 37
) (
	input  logic [$clog2(DEPTH)-1:0] base,
	input  logic [$clog2(DEPTH)-1:0] offset,
	output logic [$clog2(DEPTH)-1:0] addr
);

	localparam int AW = $clog2(DEPTH);

	logic [AW:0] sum;

	// add and single conditional subtract, both operands below DEPTH
	always_comb begin
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		addr = sum[AW-1:0];
	end

endmodule

/* rtl/core/lpfs_page_reg.sv */
// ----------------------------------------------------------------------------
// lpfs_page_reg - page serialiser
//
// Holds one panel page as an 80-bit vector in stream order. Columns are
// dropped into their bit positions as they arrive from the store; the page
// then leaves as bytes, low byte first, shifting zeros in from the top.
// ----------------------------------------------------------------------------
module lpfs_page_reg (
	input  logic                 clk,
	input  lpfs_pkg::page_ctl_t  ctl,
	input  logic [7:0]           col_data,
	output logic [7:0]           page_byte
);

	logic [lpfs_pkg::PageBits-1:0] sh_q;

	// stream bit r holds row r/10, column 9 - r%10; blink bits stay zero
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			sh_q <= '0;
		end else if (ctl.shift) begin
			sh_q <= {8'h00, sh_q[lpfs_pkg::PageBits-1:8]};
		end else if (ctl.we) begin
			for (int r = 0; r < lpfs_pkg::PageBits; r++) begin
				if ((r % lpfs_pkg::BitsPerRow) != 0 &&
				    ctl.idx == 4'(lpfs_pkg::BitsPerRow - 1 - (r % lpfs_pkg::BitsPerRow))) begin
					sh_q[r] <= col_data[r / lpfs_pkg::BitsPerRow];
				end
			end
		end
	end

	assign page_byte = sh_q[7:0];

endmodule

/* rtl/core/led_panel_frame_store_unit.sv */
// ----------------------------------------------------------------------------
// led_panel_frame_store_unit - column frame store for a chain of LED panels
//
// Pixel write/read, rotate left, clear and flush of an 8-row column store.
// ----------------------------------------------------------------------------
// The store holds LAST_COLUMN+1 columns of 8 bits in a RAM; rotation moves a
// base offset and clear drops per-column valid bits, so both leave the block
// ready again at once. Pixel write and read each go through accept, address add
// with RAM read, and modify or answer; a write outside the store is dropped in
// its accepting cycle and a read outside it skips the RAM read and answers zero.
// A flush works page by page: it reads the nine columns of a page through the
// single RAM read port, waits for the last column to land, then sends the ten
// bytes of the page, and gives PANELS*10 results in all. One command is worked
// on at a time; the next is taken once the sequencer is back in idle, while a
// finished result may still wait in the output register.
// ----------------------------------------------------------------------------
module led_panel_frame_store_unit #(
	parameter int PANELS      = 4,
	parameter int LAST_COLUMN = 36
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic signed [15:0] column,
	input  logic signed [15:0] row,
	input  logic               pixel_on,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [7:0]         data,
	output logic               last
);

	localparam int Depth  = LAST_COLUMN + 1;
	localparam int AW     = $clog2(Depth);
	localparam int FlCols = PANELS * lpfs_pkg::ColsPerPage;
	localparam int ColMax = (FlCols > Depth) ? FlCols : Depth;
	localparam int CW     = $clog2(ColMax + 1);
	localparam int PW     = (PANELS > 1) ? $clog2(PANELS) : 1;

	// sequencer states
	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StPixRd  = 3'd1;
	localparam logic [2:0] StPixOp  = 3'd2;
	localparam logic [2:0] StFlRd   = 3'd3;
	localparam logic [2:0] StFlEmit = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       cmd_q;
	logic             hit_q;
	logic [AW-1:0]    off_q;
	logic [Depth-1:0] vld_q;
	logic [PW-1:0]    page_q;
	logic [3:0]       j_q;
	logic [CW-1:0]    col_q;
	logic [3:0]       byte_q;
	logic             out_valid_q;

	logic [AW-1:0]    col_in_q;
	logic [2:0]       row_in_q;
	logic             on_q;
	logic [AW-1:0]    pix_addr_q;

	logic             rd_pend_s1;
	logic [3:0]       rd_j_s1;
	logic             rd_vld_s1;

	logic             kind_q;
	logic [7:0]       data_q;
	logic             last_q;

	logic             in_acc;
	logic             col_ok;
	logic             row_ok;
	logic [AW-1:0]    wrap_in;
	logic [AW-1:0]    phys;
	logic             fl_rd;
	logic             ram_re;
	logic             ram_we;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;
	logic [7:0]       rd_byte;
	logic [7:0]       pix_mask;
	logic             slot_free;
	logic             pix_go;
	logic             emit_go;
	logic             page_last;
	logic             byte_end;
	logic [7:0]       page_byte;
	lpfs_pkg::page_ctl_t page_ctl;

	// handshake and range checks
	assign in_stall = (state_q != StIdle);
	assign in_acc   = in_valid && !in_stall;
	assign col_ok   = !column[15] && (column <= 16'(LAST_COLUMN));
	assign row_ok   = !row[15] && (row[14:3] == '0);

	// shared address unit: pixel column or flush column
	assign wrap_in = (state_q == StFlRd) ? col_q[AW-1:0] : col_in_q;

	lpfs_addr_wrap #(
		.DEPTH (Depth)
	) u_wrap (
		.base   (wrap_in),
		.offset (off_q),
		.addr   (phys)
	);

	// store access
	assign fl_rd     = (state_q == StFlRd) && (j_q != 4'(lpfs_pkg::ColsPerPage)) &&
	                   (col_q <= CW'(LAST_COLUMN));
	assign ram_re    = (state_q == StPixRd) || fl_rd;
	assign rd_byte   = rd_vld_s1 ? ram_rdata : 8'h00;
	assign pix_mask  = 8'b1 << row_in_q;
	assign ram_we    = (state_q == StPixOp) && (cmd_q == lpfs_pkg::CmdWrite);
	assign ram_wdata = on_q ? (rd_byte | pix_mask) : (rd_byte & ~pix_mask);

	lpfs_ram #(
		.WIDTH (8),
		.DEPTH (Depth)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pix_addr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (phys),
		.rdata (ram_rdata)
	);

	// output slot and emit conditions
	assign slot_free = !out_valid_q || !out_stall;
	assign pix_go    = (state_q == StPixOp) && (cmd_q == lpfs_pkg::CmdRead) && slot_free;
	assign emit_go   = (state_q == StFlEmit) && slot_free;
	assign page_last = (page_q == PW'(PANELS - 1));
	assign byte_end  = (byte_q == 4'(lpfs_pkg::BytesPerPage - 1));

	// page serialiser control
	always_comb begin
		page_ctl.clr   = (state_q == StFlRd) && (j_q == 4'd0);
		page_ctl.we    = rd_pend_s1;
		page_ctl.idx   = rd_j_s1;
		page_ctl.shift = emit_go;
	end

	lpfs_page_reg u_page (
		.clk       (clk),
		.ctl       (page_ctl),
		.col_data  (rd_byte),
		.page_byte (page_byte)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			cmd_q       <= lpfs_pkg::CmdWrite;
			hit_q       <= 1'b0;
			off_q       <= '0;
			vld_q       <= '0;
			page_q      <= '0;
			j_q         <= '0;
			col_q       <= '0;
			byte_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= fl_rd;

			if (pix_go || emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				StIdle: begin
					if (in_acc) begin
						cmd_q <= command;
						unique case (command)
							lpfs_pkg::CmdWrite: begin
								if (col_ok && row_ok) begin
									state_q <= StPixRd;
								end
							end
							lpfs_pkg::CmdRead: begin
								hit_q   <= col_ok && row_ok;
								state_q <= (col_ok && row_ok) ? StPixRd : StPixOp;
							end
							lpfs_pkg::CmdRotate: begin
								off_q <= (off_q == AW'(LAST_COLUMN)) ? '0 : off_q + 1'b1;
							end
							lpfs_pkg::CmdClear: begin
								vld_q <= '0;
							end
							lpfs_pkg::CmdFlush: begin
								page_q  <= '0;
								j_q     <= '0;
								col_q   <= '0;
								byte_q  <= '0;
								state_q <= StFlRd;
							end
							default: begin
								// unused codes: no effect
							end
						endcase
					end
				end
				StPixRd: begin
					state_q <= StPixOp;
				end
				StPixOp: begin
					if (cmd_q == lpfs_pkg::CmdWrite) begin
						vld_q[pix_addr_q] <= 1'b1;
						state_q           <= StIdle;
					end else if (slot_free) begin
						state_q <= StIdle;
					end
				end
				StFlRd: begin
					// a final pass with no read lets the last column land
					if (j_q == 4'(lpfs_pkg::ColsPerPage)) begin
						byte_q  <= '0;
						state_q <= StFlEmit;
					end else begin
						j_q   <= j_q + 1'b1;
						col_q <= col_q + 1'b1;
					end
				end
				StFlEmit: begin
					if (slot_free) begin
						byte_q <= byte_q + 1'b1;
						if (byte_end) begin
							if (page_last) begin
								state_q <= StIdle;
							end else begin
								page_q  <= page_q + 1'b1;
								j_q     <= '0;
								state_q <= StFlRd;
							end
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_in_q <= column[AW-1:0];
			row_in_q <= row[2:0];
			on_q     <= pixel_on;
		end
		if (state_q == StPixRd) begin
			pix_addr_q <= phys;
		end
		if (ram_re) begin
			rd_vld_s1 <= vld_q[phys];
		end
		rd_j_s1 <= j_q;

		if (pix_go) begin
			kind_q <= lpfs_pkg::KindPixel;
			data_q <= (hit_q && rd_byte[row_in_q]) ? lpfs_pkg::PixelSet : 8'h00;
			last_q <= 1'b1;
		end else if (emit_go) begin
			kind_q <= lpfs_pkg::KindPanel;
			data_q <= page_byte;
			last_q <= page_last && byte_end;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data      = data_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	// rotation offset stays inside the store
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= AW'(LAST_COLUMN))
		else $error("rotation offset beyond store depth");

	// the final panel byte returns the sequencer to idle
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && page_last && byte_end |=> state_q == StIdle)
		else $error("flush did not end after its last byte");

	// a pixel answer is all ones or all zeros
	a_pix_answer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == lpfs_pkg::KindPixel |->
			data == 8'h00 || data == lpfs_pkg::PixelSet)
		else $error("malformed pixel answer");
`endif

endmodule

/* tb/sv/tb_led_panel_frame_store_unit.sv */
// ----------------------------------------------------------------------------
// tb_led_panel_frame_store_unit - self-checking bench for the LED frame store
//
// Firmware commands go in over the command channel and every pixel answer and
// panel byte that comes out is checked, in order, against a predictor with its
// own copy of the column store. A directed opening covers store edges,
// out-of-range coordinates, every command and the unused codes. A long random
// run follows, with random gaps and stalls on both sides, one long output
// hold-off, one full drain and two stretches with no idling.
// ----------------------------------------------------------------------------
module tb_led_panel_frame_store_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PANELS      = 4;
	localparam int LAST_COLUMN = 36;
	localparam int FlushBytes  = PANELS * lpfs_pkg::BytesPerPage;
	localparam int RandomItems = 380;
	localparam int HoldCycles  = 400;
	localparam int DrainCycles = 100;
	localparam int ReportLimit = 10;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} panel_result_t;

	// predicted frame store and the queue of results still owed by the block
	class frame_scoreboard;
		logic [7:0]    cols [LAST_COLUMN+1];
		panel_result_t awaited [$];
		int            mismatches;
		int            checked;

		function new();
			foreach (cols[j]) cols[j] = 8'h00;
			mismatches = 0;
			checked    = 0;
		endfunction

		function bit in_frame(logic signed [15:0] x, logic signed [15:0] y);
			return x >= 0 && x <= LAST_COLUMN && y >= 0 && y <= 7;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// bit i of the panel stream; the first bit of each row is the blink bit
		function logic panel_bit(int i);
			int page;
			int r;
			int pos;
			int col;
			page = i / lpfs_pkg::PageBits;
			r    = i % lpfs_pkg::PageBits;
			pos  = r % lpfs_pkg::BitsPerRow;
			col  = lpfs_pkg::BitsPerRow - 1 - pos + page * lpfs_pkg::ColsPerPage;
			if (pos == 0 || col > LAST_COLUMN)
				return 1'b0;
			return cols[col][r / lpfs_pkg::BitsPerRow];
		endfunction

		// accepted command: update the store and queue what it should produce
		function void note_command(logic [2:0] cmd, logic signed [15:0] x,
			logic signed [15:0] y, logic on);
			logic [7:0]    wrap;
			panel_result_t res;
			int            b;
			int            k;
			case (cmd)
				lpfs_pkg::CmdWrite: begin
					if (in_frame(x, y))
						cols[int'(x)][int'(y)] = on;
				end
				lpfs_pkg::CmdRead: begin
					res.kind = lpfs_pkg::KindPixel;
					res.data = 8'h00;
					if (in_frame(x, y) && cols[int'(x)][int'(y)])
						res.data = lpfs_pkg::PixelSet;
					res.last = 1'b1;
					awaited.push_back(res);
				end
				lpfs_pkg::CmdRotate: begin
					wrap = cols[0];
					for (b = 0; b < LAST_COLUMN; b++)
						cols[b] = cols[b + 1];
					cols[LAST_COLUMN] = wrap;
				end
				lpfs_pkg::CmdClear: begin
					foreach (cols[j]) cols[j] = 8'h00;
				end
				lpfs_pkg::CmdFlush: begin
					for (b = 0; b < FlushBytes; b++) begin
						res.kind = lpfs_pkg::KindPanel;
						res.data = 8'h00;
						for (k = 0; k < 8; k++)
							res.data[k] = panel_bit(b * 8 + k);
						res.last = (b == FlushBytes - 1);
						awaited.push_back(res);
					end
				end
				default: ;  // unused codes are dropped
			endcase
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= ReportLimit)
				$display("mismatch %0d at %0t: %s", mismatches, $time, msg);
		endfunction

		// accepted result: compare with the oldest prediction
		function void check_result(logic k, logic [7:0] d, logic l);
			panel_result_t want;
			checked++;
			if (awaited.size() == 0) begin
				flag($sformatf("unexpected result kind %0d data %02h last %0d", k, d, l));
				return;
			end
			want = awaited.pop_front();
			if (want.kind !== k || want.data !== d || want.last !== l)
				flag($sformatf("kind/data/last expected %0d/%02h/%0d, got %0d/%02h/%0d",
					want.kind, want.data, want.last, k, d, l));
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [2:0]         command   = lpfs_pkg::CmdWrite;
	logic signed [15:0] column    = 16'sd0;
	logic signed [15:0] row       = 16'sd0;
	logic               pixel_on  = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               kind;
	logic [7:0]         data;
	logic               last;

	frame_scoreboard sb;
	bit              no_idle   = 1'b0;
	bit              hold_req  = 1'b0;
	logic            long_hold = 1'b0;
	int              cmd_count [8];
	int              sent      = 0;

	led_panel_frame_store_unit #(
		.PANELS      (PANELS),
		.LAST_COLUMN (LAST_COLUMN)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.column    (column),
		.row       (row),
		.pixel_on  (pixel_on),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data      (data),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// overall limit, far above the slowest legal run
	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// long output hold-off, counted here once the sender asks for it
	initial begin
		wait (hold_req);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		long_hold <= 1'b0;
	end

	// result side: take a transaction, then stall for a drawn number of cycles
	initial begin
		int wait_left;
		wait_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(kind, data, last);
				wait_left = no_idle ? 0 : $urandom_range(0, 6);
			end else if (wait_left > 0) begin
				wait_left--;
			end
			out_stall <= long_hold || (wait_left > 0);
		end
	end

	// one command transaction; valid stays high only if the next one follows at once
	task automatic send_command(input logic [2:0] cmd, input logic signed [15:0] x,
		input logic signed [15:0] y, input logic on);
		int gap;
		command  <= cmd;
		column   <= x;
		row      <= y;
		pixel_on <= on;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_command(cmd, x, y, on);
		cmd_count[cmd]++;
		sent++;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_column();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 8)
			return 16'($urandom_range(0, LAST_COLUMN));
		if (sel == 8)
			return $urandom_range(0, 1) ? -16'sd1 : 16'(LAST_COLUMN + 1);
		return 16'($urandom());
	endfunction

	function automatic logic signed [15:0] pick_row();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 8)
			return 16'($urandom_range(0, 7));
		if (sel == 8)
			return $urandom_range(0, 1) ? -16'sd1 : 16'sd8;
		return 16'($urandom());
	endfunction

	initial begin
		int                 sel;
		int                 j;
		bit                 pressure_done;
		bit                 pause_done;
		logic signed [15:0] x;
		logic signed [15:0] y;

		sb            = new();
		pressure_done = 1'b0;
		pause_done    = 1'b0;
		foreach (cmd_count[i]) cmd_count[i] = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// directed: empty store, store corners and page edges, bad coordinates
		send_command(lpfs_pkg::CmdRead, 16'sd0, 16'sd0, 1'b0);
		send_command(lpfs_pkg::CmdFlush, 16'sd0, 16'sd0, 1'b0);
		send_command(lpfs_pkg::CmdWrite, 16'sd0, 16'sd0, 1'b1);
		send_command(lpfs_pkg::CmdWrite, 16'(LAST_COLUMN), 16'sd7, 1'b1);
		send_command(lpfs_pkg::CmdWrite, 16'sd8, 16'sd3, 1'b1);
		send_command(lpfs_pkg::CmdWrite, 16'sd9, 16'sd5, 1'b1);
		send_command(lpfs_pkg::CmdWrite, 16'sd35, 16'sd1, 1'b1);
		send_command(lpfs_pkg::CmdWrite, -16'sd1, 16'sd0, 1'b1);
		send_command(lpfs_pkg::CmdWrite, 16'(LAST_COLUMN + 1), 16'sd0, 1'b1);
		send_command(lpfs_pkg::CmdWrite, 16'sd0, 16'sd8, 1'b1);
		send_command(lpfs_pkg::CmdWrite, 16'sd1, -16'sd1, 1'b1);
		send_command(lpfs_pkg::CmdWrite, -16'sd32768, 16'sd32767, 1'b1);
		send_command(lpfs_pkg::CmdWrite, 16'sd32767, -16'sd32768, 1'b1);
		send_command(lpfs_pkg::CmdRead, 16'sd0, 16'sd0, 1'b0);
		send_command(lpfs_pkg::CmdRead, 16'(LAST_COLUMN), 16'sd7, 1'b1);
		send_command(lpfs_pkg::CmdRead, -16'sd1, 16'sd0, 1'b0);
		send_command(lpfs_pkg::CmdRead, 16'sd0, 16'sd8, 1'b0);
		send_command(lpfs_pkg::CmdFlush, 16'sd0, 16'sd0, 1'b0);
		send_command(lpfs_pkg::CmdRotate, -16'sd1, -16'sd1, 1'b1);
		send_command(lpfs_pkg::CmdRead, 16'(LAST_COLUMN), 16'sd0, 1'b0);
		send_command(lpfs_pkg::CmdFlush, 16'sd0, 16'sd0, 1'b0);
		send_command(lpfs_pkg::CmdWrite, 16'(LAST_COLUMN), 16'sd0, 1'b0);
		send_command(3'd5, -16'sd1, -16'sd1, 1'b1);
		send_command(3'd6, 16'sd0, 16'sd0, 1'b0);
		send_command(3'd7, 16'sd1, 16'sd1, 1'b1);
		send_command(lpfs_pkg::CmdClear, 16'sd0, 16'sd0, 1'b0);
		send_command(lpfs_pkg::CmdRead, 16'(LAST_COLUMN), 16'sd7, 1'b0);
		send_command(lpfs_pkg::CmdFlush, 16'sd0, 16'sd0, 1'b0);
		in_valid <= 1'b0;
		wait_drained();
		sent = 0;

		// random part: mostly in-range pixel traffic with occasional flushes
		while (sent < RandomItems) begin
			if (!pressure_done && sent >= 120) begin
				// output held off while flushes and reads pile up at the input
				pressure_done = 1'b1;
				hold_req      = 1'b1;
				no_idle       = 1'b1;
				for (j = 0; j < 12; j++)
					send_command((j % 3 == 0) ? lpfs_pkg::CmdFlush : lpfs_pkg::CmdRead,
						pick_column(), pick_row(), 1'b0);
				no_idle = 1'b0;
			end
			if (!pause_done && sent >= 250) begin
				pause_done = 1'b1;
				in_valid <= 1'b0;
				wait_drained();
			end
			no_idle = (sent >= 300 && sent < 350);
			sel = $urandom_range(0, 99);
			x   = pick_column();
			y   = pick_row();
			if (sel < 38) begin
				send_command(lpfs_pkg::CmdWrite, x, y, 1'($urandom_range(0, 1)));
			end else if (sel < 50) begin
				// write then read back the same pixel
				x = 16'($urandom_range(0, LAST_COLUMN));
				y = 16'($urandom_range(0, 7));
				send_command(lpfs_pkg::CmdWrite, x, y, 1'($urandom_range(0, 1)));
				send_command(lpfs_pkg::CmdRead, x, y, 1'($urandom_range(0, 1)));
			end else if (sel < 70) begin
				send_command(lpfs_pkg::CmdRead, x, y, 1'($urandom_range(0, 1)));
			end else if (sel < 78) begin
				send_command(lpfs_pkg::CmdRotate, 16'($urandom()), 16'($urandom()),
					1'($urandom_range(0, 1)));
			end else if (sel < 81) begin
				send_command(lpfs_pkg::CmdClear, 16'($urandom()), 16'($urandom()),
					1'($urandom_range(0, 1)));
			end else if (sel < 88) begin
				send_command(lpfs_pkg::CmdFlush, 16'($urandom()), 16'($urandom()),
					1'($urandom_range(0, 1)));
			end else if (sel < 93) begin
				send_command(3'($urandom_range(5, 7)), 16'($urandom()), 16'($urandom()),
					1'($urandom_range(0, 1)));
			end else begin
				send_command(lpfs_pkg::CmdWrite, 16'($urandom()), 16'($urandom()),
					1'($urandom_range(0, 1)));
			end
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		wait_drained();
		repeat (DrainCycles) @(posedge clk);

		$display("Covered %0d writes, %0d reads, %0d rotates, %0d clears, %0d flushes,",
			cmd_count[lpfs_pkg::CmdWrite], cmd_count[lpfs_pkg::CmdRead],
			cmd_count[lpfs_pkg::CmdRotate], cmd_count[lpfs_pkg::CmdClear],
			cmd_count[lpfs_pkg::CmdFlush]);
		$display("%0d unused codes; %0d results compared, %0d failures.",
			cmd_count[5] + cmd_count[6] + cmd_count[7], sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
